// ----- hw/rtl/tce_pkg.sv -----
// Shared types and constants of the tiny CPU execute core.
// Opcode, error and request codes, configuration register indexes and
// the result record. No dependencies.
package tce_pkg;

  // Field widths of the channel payloads.
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IMM_W     = 16;
  localparam int unsigned OP_W      = 4;
  localparam int unsigned RIDX_W    = 4;
  localparam int unsigned IRQ_W     = 5;
  localparam int unsigned ERR_W     = 2;
  localparam int unsigned RCNT_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // Request kinds.
  localparam logic REQ_IRQ  = 1'b0;
  localparam logic REQ_EXEC = 1'b1;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_NOP  = 4'd0;
  localparam logic [OP_W-1:0] OP_MOVI = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD = 4'd2;
  localparam logic [OP_W-1:0] OP_STORE = 4'd3;
  localparam logic [OP_W-1:0] OP_MOV  = 4'd4;
  localparam logic [OP_W-1:0] OP_ADD  = 4'd5;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd6;
  localparam logic [OP_W-1:0] OP_CMP  = 4'd7;
  localparam logic [OP_W-1:0] OP_JMP  = 4'd8;
  localparam logic [OP_W-1:0] OP_JZ   = 4'd9;
  localparam logic [OP_W-1:0] OP_JNZ  = 4'd10;
  localparam logic [OP_W-1:0] OP_CMPI = 4'd11;
  localparam logic [OP_W-1:0] OP_RETI = 4'd12;
  localparam logic [OP_W-1:0] OP_HALT = 4'd13;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_REG = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_OP  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_NO_IRQ  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_BASE = 1'd1;

  localparam logic [RCNT_W-1:0] RCNT_RESET = 5'd16;

  // One result record as held in the output register.
  typedef struct packed {
    logic [WORD_W-1:0] pc_next;
    logic              is_halted;
    logic              zero_out;
    logic              in_handler;
    logic              write_valid;
    logic [IMM_W-1:0]  write_addr;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] read_addr;
    logic              irq_ack_valid;
    logic [IRQ_W-1:0]  irq_ack_number;
    logic [ERR_W-1:0]  error_code;
  } result_t;

endpackage

// ----- hw/rtl/tce_in_if.sv -----
// Input channel of the execute core: one request per transaction.
// Depends on tce_pkg for field widths.
interface tce_in_if;
  import tce_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [IRQ_W-1:0]  irq_number;
  logic [WORD_W-1:0] vector_word;
  logic [OP_W-1:0]   op_code;
  logic [RIDX_W-1:0] dest_reg;
  logic [RIDX_W-1:0] src_reg;
  logic [IMM_W-1:0]  imm_value;
  logic [WORD_W-1:0] load_word;

  modport source (
    output valid, req_type, irq_number, vector_word, op_code, dest_reg, src_reg,
           imm_value, load_word,
    input  ready
  );

  modport sink (
    input  valid, req_type, irq_number, vector_word, op_code, dest_reg, src_reg,
           imm_value, load_word,
    output ready
  );
endinterface

// ----- hw/rtl/tce_out_if.sv -----
// Result channel of the execute core: one result record per transaction.
// Depends on tce_pkg for field widths.
interface tce_out_if;
  import tce_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] pc_next;
  logic              is_halted;
  logic              zero_out;
  logic              in_handler;
  logic              write_valid;
  logic [IMM_W-1:0]  write_addr;
  logic [WORD_W-1:0] write_data;
  logic [WORD_W-1:0] read_addr;
  logic              irq_ack_valid;
  logic [IRQ_W-1:0]  irq_ack_number;
  logic [ERR_W-1:0]  error_code;

  modport source (
    output valid, pc_next, is_halted, zero_out, in_handler, write_valid,
           write_addr, write_data, read_addr, irq_ack_valid, irq_ack_number,
           error_code,
    input  ready
  );

  modport sink (
    input  valid, pc_next, is_halted, zero_out, in_handler, write_valid,
           write_addr, write_data, read_addr, irq_ack_valid, irq_ack_number,
           error_code,
    output ready
  );
endinterface

// ----- hw/rtl/tce_cfg_if.sv -----
// Configuration write channel of the execute core.
// Depends on tce_pkg for the index and data widths.
interface tce_cfg_if;
  import tce_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [WORD_W-1:0]    wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ----- hw/rtl/tiny_cpu_execute_core.sv -----
// Execute core of a small register machine: request register, register file,
// one-pass execute logic and result register.
// Depends on tce_pkg, tce_in_if, tce_out_if and tce_cfg_if.
//
// Usage:
//   in_ch carries one request per transaction: an interrupt entry or one
//   decoded instruction together with the bus words it needs. out_ch returns
//   exactly one result record per request, in order. cfg_ch writes the
//   register count (index 0) and the vector base (index 1); it is always
//   ready and must only be used while no request is in flight.
//   A request passes through the request register (register file read) and
//   then the result register. Throughput is one request per cycle while
//   the receiver does not stall; the architectural state is updated
//   when a request leaves the request register, so the next request already
//   sees it, with a bypass from the register file write port.
//   Reset clears the program counter, flags, saved return address, all
//   general registers (through per-register valid bits) and both
//   configuration registers to their defaults.
//   When the receiver stalls, the result register holds and the request
//   register fills; in_ch.ready drops only once both are occupied.
module tiny_cpu_execute_core #(
  parameter int unsigned MAX_REGS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tce_in_if.sink    in_ch,
  tce_out_if.source out_ch,
  tce_cfg_if.sink   cfg_ch
);
  import tce_pkg::*;

  localparam int unsigned IDX_W    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int unsigned RF_DEPTH = 1 << IDX_W;
  localparam logic [RCNT_W-1:0] MAX_N = RCNT_W'(MAX_REGS);

  // Configuration registers.
  logic [RCNT_W-1:0] reg_count_r;
  logic [WORD_W-1:0] vector_base_r;

  // Architectural state.
  logic [WORD_W-1:0] pc_r, pc_nxt;
  logic              halt_r, halt_nxt;
  logic              zf_r, zf_nxt;
  logic [WORD_W-1:0] ret_pc_r, ret_pc_nxt;
  logic              hact_r, hact_nxt;

  // Register file with reset-cleared valid bits.
  logic [WORD_W-1:0]   gp_mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] gp_vld_r;

  // Request register.
  logic              s1_v_r;
  logic              s1_req_r;
  logic [IRQ_W-1:0]  s1_irq_r;
  logic [WORD_W-1:0] s1_vword_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [RIDX_W-1:0] s1_rd_r;
  logic [RIDX_W-1:0] s1_rs_r;
  logic [IMM_W-1:0]  s1_imm_r;
  logic [WORD_W-1:0] s1_lword_r;
  logic [WORD_W-1:0] opa_r;
  logic [WORD_W-1:0] opb_r;

  // Result register.
  logic    out_v_r;
  result_t res_r, res_nxt;

  // Handshake and register file write port.
  logic              in_acc;
  logic              s1_adv;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic              wr_fire;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  rs_idx;

  // Operand checks.
  logic [RCNT_W-1:0] n_eff;
  logic              rd_ok;
  logic              both_ok;
  logic [WORD_W-1:0] imm_ext;

  assign s1_adv = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_count_r   <= RCNT_RESET;
      vector_base_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_REG_COUNT:   reg_count_r   <= cfg_ch.wr_data[RCNT_W-1:0];
        CFG_VECTOR_BASE: vector_base_r <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  // Request register: payload and registered register file reads with bypass.
  assign wr_fire = s1_adv && wr_en;
  assign wr_idx  = s1_rd_r[IDX_W-1:0];
  assign rd_idx  = in_ch.dest_reg[IDX_W-1:0];
  assign rs_idx  = in_ch.src_reg[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r   <= in_ch.req_type;
      s1_irq_r   <= in_ch.irq_number;
      s1_vword_r <= in_ch.vector_word;
      s1_op_r    <= in_ch.op_code;
      s1_rd_r    <= in_ch.dest_reg;
      s1_rs_r    <= in_ch.src_reg;
      s1_imm_r   <= in_ch.imm_value;
      s1_lword_r <= in_ch.load_word;
      if (wr_fire && (s1_rd_r == in_ch.dest_reg)) begin
        opa_r <= wr_data;
      end else begin
        opa_r <= gp_vld_r[rd_idx] ? gp_mem[rd_idx] : '0;
      end
      if (wr_fire && (s1_rd_r == in_ch.src_reg)) begin
        opb_r <= wr_data;
      end else begin
        opb_r <= gp_vld_r[rs_idx] ? gp_mem[rs_idx] : '0;
      end
    end
  end

  // Register file write port.
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      gp_mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_vld_r <= '0;
    end else if (wr_fire) begin
      gp_vld_r[wr_idx] <= 1'b1;
    end
  end

  // Effective register count, clamped to the implemented range.
  always_comb begin
    if (reg_count_r == '0) begin
      n_eff = RCNT_W'(1);
    end else if (reg_count_r > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = reg_count_r;
    end
  end

  assign rd_ok   = {1'b0, s1_rd_r} < n_eff;
  assign both_ok = rd_ok && ({1'b0, s1_rs_r} < n_eff);
  assign imm_ext = {{(WORD_W-IMM_W){1'b0}}, s1_imm_r};

  // Execute: next architectural state and the result record.
  always_comb begin
    pc_nxt     = pc_r;
    halt_nxt   = halt_r;
    zf_nxt     = zf_r;
    ret_pc_nxt = ret_pc_r;
    hact_nxt   = hact_r;
    wr_en      = 1'b0;
    wr_data    = '0;
    res_nxt    = '0;
    res_nxt.error_code = ERR_OK;

    if (s1_req_r == REQ_IRQ) begin
      // Interrupt entry, ignored while a handler runs.
      if (!hact_r) begin
        ret_pc_nxt = pc_r;
        pc_nxt     = s1_vword_r;
        hact_nxt   = 1'b1;
        halt_nxt   = 1'b0;
        res_nxt.read_addr      = vector_base_r + {{(WORD_W-IRQ_W){1'b0}}, s1_irq_r};
        res_nxt.irq_ack_valid  = 1'b1;
        res_nxt.irq_ack_number = s1_irq_r;
      end
    end else if (!halt_r) begin
      pc_nxt = pc_r + WORD_W'(1);
      unique case (s1_op_r)
        OP_NOP: ;
        OP_MOVI: begin
          if (rd_ok) begin
            wr_en   = 1'b1;
            wr_data = imm_ext;
          end else begin
            res_nxt.error_code = ERR_BAD_REG;
          end
        end
        OP_LOAD: begin
          if (rd_ok) begin
            wr_en   = 1'b1;
            wr_data = s1_lword_r;
            res_nxt.read_addr = imm_ext;
          end else begin
            res_nxt.error_code = ERR_BAD_REG;
          end
        end
        OP_STORE: begin
          if (rd_ok) begin
            res_nxt.write_valid = 1'b1;
            res_nxt.write_addr  = s1_imm_r;
            res_nxt.write_data  = opa_r;
          end else begin
            res_nxt.error_code = ERR_BAD_REG;
          end
        end
        OP_MOV: begin
          if (both_ok) begin
            wr_en   = 1'b1;
            wr_data = opb_r;
          end else begin
            res_nxt.error_code = ERR_BAD_REG;
          end
        end
        OP_ADD: begin
          if (both_ok) begin
            wr_en   = 1'b1;
            wr_data = opa_r + opb_r;
          end else begin
            res_nxt.error_code = ERR_BAD_REG;
          end
        end
        OP_SUB: begin
          if (both_ok) begin
            wr_en   = 1'b1;
            wr_data = opa_r - opb_r;
          end else begin
            res_nxt.error_code = ERR_BAD_REG;
          end
        end
        OP_CMP: begin
          if (both_ok) begin
            zf_nxt = (opa_r == opb_r);
          end else begin
            res_nxt.error_code = ERR_BAD_REG;
          end
        end
        OP_JMP: pc_nxt = imm_ext;
        OP_JZ: begin
          if (zf_r) begin
            pc_nxt = imm_ext;
          end
        end
        OP_JNZ: begin
          if (!zf_r) begin
            pc_nxt = imm_ext;
          end
        end
        OP_CMPI: begin
          if (rd_ok) begin
            zf_nxt = (opa_r == imm_ext);
          end else begin
            res_nxt.error_code = ERR_BAD_REG;
          end
        end
        OP_RETI: begin
          if (hact_r) begin
            pc_nxt   = ret_pc_r;
            hact_nxt = 1'b0;
          end else begin
            res_nxt.error_code = ERR_NO_IRQ;
          end
        end
        OP_HALT: halt_nxt = 1'b1;
        default: res_nxt.error_code = ERR_BAD_OP;
      endcase
    end

    res_nxt.pc_next    = pc_nxt;
    res_nxt.is_halted  = halt_nxt;
    res_nxt.zero_out   = zf_nxt;
    res_nxt.in_handler = hact_nxt;
  end

  // Architectural state update as a request leaves the request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      halt_r   <= 1'b0;
      zf_r     <= 1'b0;
      ret_pc_r <= '0;
      hact_r   <= 1'b0;
    end else if (s1_adv) begin
      pc_r     <= pc_nxt;
      halt_r   <= halt_nxt;
      zf_r     <= zf_nxt;
      ret_pc_r <= ret_pc_nxt;
      hact_r   <= hact_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.pc_next        = res_r.pc_next;
  assign out_ch.is_halted      = res_r.is_halted;
  assign out_ch.zero_out       = res_r.zero_out;
  assign out_ch.in_handler     = res_r.in_handler;
  assign out_ch.write_valid    = res_r.write_valid;
  assign out_ch.write_addr     = res_r.write_addr;
  assign out_ch.write_data     = res_r.write_data;
  assign out_ch.read_addr      = res_r.read_addr;
  assign out_ch.irq_ack_valid  = res_r.irq_ack_valid;
  assign out_ch.irq_ack_number = res_r.irq_ack_number;
  assign out_ch.error_code     = res_r.error_code;

endmodule

// ----- bench/tiny_cpu_execute_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the tiny CPU execute core: directed and random instruction streams,
// predicted by an architectural model of the core and checked result by result.
// Depends on tce_pkg, the three channel interfaces and tiny_cpu_execute_core.
module tiny_cpu_execute_core_tb;
  import tce_pkg::*;

  localparam int unsigned MAX_GPR = 16;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PRINT_LIMIT = 100;

  // Opcode values that the core does not define.
  localparam logic [OP_W-1:0] OP_UNUSED_A = 4'd14;
  localparam logic [OP_W-1:0] OP_UNUSED_B = 4'd15;

  // One request as offered on the input channel.
  typedef struct packed {
    logic              req_type;
    logic [IRQ_W-1:0]  irq_number;
    logic [WORD_W-1:0] vector_word;
    logic [OP_W-1:0]   op_code;
    logic [RIDX_W-1:0] dest_reg;
    logic [RIDX_W-1:0] src_reg;
    logic [IMM_W-1:0]  imm_value;
    logic [WORD_W-1:0] load_word;
  } cpu_req_t;

  logic clk;
  logic rst_n;

  tce_in_if  in_ch ();
  tce_out_if out_ch ();
  tce_cfg_if cfg_ch ();

  tiny_cpu_execute_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Architectural state of the core as the predictor sees it.
  logic [WORD_W-1:0] st_pc;
  logic [WORD_W-1:0] st_gpr [MAX_GPR];
  logic              st_halted;
  logic              st_zero;
  logic [WORD_W-1:0] st_ret_pc;
  logic              st_in_isr;
  logic [RCNT_W-1:0] cfg_reg_count;
  logic [WORD_W-1:0] cfg_vector_base;

  // Halt and handler flags as the stimulus generator expects them to become.
  bit gen_in_isr;
  bit gen_halted;

  result_t     pending_results [$];
  cpu_req_t    seen_req;
  result_t     want_res;
  result_t     got_res;
  int unsigned result_num;
  int unsigned err_count;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned stall_hold;
  int unsigned quiet_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Reset values of the predicted state and configuration.
  task automatic reset_state();
    st_pc = '0;
    foreach (st_gpr[i]) st_gpr[i] = '0;
    st_halted = 1'b0;
    st_zero = 1'b0;
    st_ret_pc = '0;
    st_in_isr = 1'b0;
    cfg_reg_count = RCNT_RESET;
    cfg_vector_base = '0;
  endtask

  // Number of general registers that the current register count enables.
  function automatic int unsigned regs_enabled();
    if (cfg_reg_count == 0) return 1;
    if (cfg_reg_count > MAX_GPR) return MAX_GPR;
    return 32'(cfg_reg_count);
  endfunction

  // Executes one request on the predicted state and returns the result record it causes.
  task automatic execute_step(input cpu_req_t r, output result_t res);
    int unsigned n;
    bit rd_ok;
    bit both_ok;
    n = regs_enabled();
    rd_ok = r.dest_reg < n;
    both_ok = rd_ok && (r.src_reg < n);
    res = '0;
    if (r.req_type == REQ_IRQ) begin
      // An interrupt is taken only when no handler is running.
      if (!st_in_isr) begin
        st_ret_pc = st_pc;
        res.read_addr = cfg_vector_base + {27'd0, r.irq_number};
        st_pc = r.vector_word;
        st_in_isr = 1'b1;
        st_halted = 1'b0;
        res.irq_ack_valid = 1'b1;
        res.irq_ack_number = r.irq_number;
      end
    end else if (!st_halted) begin
      st_pc = st_pc + 32'd1;
      unique case (r.op_code)
        OP_NOP: ;
        OP_MOVI: begin
          if (rd_ok) st_gpr[r.dest_reg] = {16'd0, r.imm_value};
          else res.error_code = ERR_BAD_REG;
        end
        OP_LOAD: begin
          if (rd_ok) begin
            st_gpr[r.dest_reg] = r.load_word;
            res.read_addr = {16'd0, r.imm_value};
          end else res.error_code = ERR_BAD_REG;
        end
        OP_STORE: begin
          if (rd_ok) begin
            res.write_valid = 1'b1;
            res.write_addr = r.imm_value;
            res.write_data = st_gpr[r.dest_reg];
          end else res.error_code = ERR_BAD_REG;
        end
        OP_MOV: begin
          if (both_ok) st_gpr[r.dest_reg] = st_gpr[r.src_reg];
          else res.error_code = ERR_BAD_REG;
        end
        OP_ADD: begin
          if (both_ok) st_gpr[r.dest_reg] = st_gpr[r.dest_reg] + st_gpr[r.src_reg];
          else res.error_code = ERR_BAD_REG;
        end
        OP_SUB: begin
          if (both_ok) st_gpr[r.dest_reg] = st_gpr[r.dest_reg] - st_gpr[r.src_reg];
          else res.error_code = ERR_BAD_REG;
        end
        OP_CMP: begin
          if (both_ok) st_zero = (st_gpr[r.dest_reg] == st_gpr[r.src_reg]);
          else res.error_code = ERR_BAD_REG;
        end
        OP_JMP: st_pc = {16'd0, r.imm_value};
        OP_JZ: if (st_zero) st_pc = {16'd0, r.imm_value};
        OP_JNZ: if (!st_zero) st_pc = {16'd0, r.imm_value};
        OP_CMPI: begin
          if (rd_ok) st_zero = (st_gpr[r.dest_reg] == {16'd0, r.imm_value});
          else res.error_code = ERR_BAD_REG;
        end
        OP_RETI: begin
          if (st_in_isr) begin
            st_pc = st_ret_pc;
            st_in_isr = 1'b0;
          end else res.error_code = ERR_NO_IRQ;
        end
        OP_HALT: st_halted = 1'b1;
        default: res.error_code = ERR_BAD_OP;
      endcase
    end
    res.pc_next = st_pc;
    res.is_halted = st_halted;
    res.zero_out = st_zero;
    res.in_handler = st_in_isr;
  endtask

  // Prints one mismatch line (up to a limit) and counts it.
  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic compare_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                result_num, name, got, want));
  endtask

  // Observes every transaction: configuration writes and requests update the
  // predictor, results are checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.reg_index == CFG_REG_COUNT) cfg_reg_count = cfg_ch.wr_data[RCNT_W-1:0];
        else cfg_vector_base = cfg_ch.wr_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_req = {in_ch.req_type, in_ch.irq_number, in_ch.vector_word, in_ch.op_code,
                    in_ch.dest_reg, in_ch.src_reg, in_ch.imm_value, in_ch.load_word};
        execute_step(seen_req, want_res);
        pending_results.push_back(want_res);
      end
      if (out_ch.valid && out_ch.ready) begin
        got_res = {out_ch.pc_next, out_ch.is_halted, out_ch.zero_out, out_ch.in_handler,
                   out_ch.write_valid, out_ch.write_addr, out_ch.write_data,
                   out_ch.read_addr, out_ch.irq_ack_valid, out_ch.irq_ack_number,
                   out_ch.error_code};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    result_num));
        end else begin
          want_res = pending_results.pop_front();
          compare_field("pc_next", got_res.pc_next, want_res.pc_next);
          compare_field("is_halted", WORD_W'(got_res.is_halted),
                        WORD_W'(want_res.is_halted));
          compare_field("zero_out", WORD_W'(got_res.zero_out),
                        WORD_W'(want_res.zero_out));
          compare_field("in_handler", WORD_W'(got_res.in_handler),
                        WORD_W'(want_res.in_handler));
          compare_field("write_valid", WORD_W'(got_res.write_valid),
                        WORD_W'(want_res.write_valid));
          compare_field("write_addr", WORD_W'(got_res.write_addr),
                        WORD_W'(want_res.write_addr));
          compare_field("write_data", got_res.write_data, want_res.write_data);
          compare_field("read_addr", got_res.read_addr, want_res.read_addr);
          compare_field("irq_ack_valid", WORD_W'(got_res.irq_ack_valid),
                        WORD_W'(want_res.irq_ack_valid));
          compare_field("irq_ack_number", WORD_W'(got_res.irq_ack_number),
                        WORD_W'(want_res.irq_ack_number));
          compare_field("error_code", WORD_W'(got_res.error_code),
                        WORD_W'(want_res.error_code));
        end
        result_num++;
      end
    end
  end

  // Result receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_hold > 0) begin
        out_ch.ready <= 1'b0;
        stall_hold = stall_hold - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no transaction of any kind happens for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Offers one request after a random idle gap and returns at the edge that accepts it.
  task automatic send_req(input cpu_req_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= r.req_type;
    in_ch.irq_number  <= r.irq_number;
    in_ch.vector_word <= r.vector_word;
    in_ch.op_code     <= r.op_code;
    in_ch.dest_reg    <= r.dest_reg;
    in_ch.src_reg     <= r.src_reg;
    in_ch.imm_value   <= r.imm_value;
    in_ch.load_word   <= r.load_word;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering requests and waits until every result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both configuration registers; the core must be idle.
  task automatic set_config(input logic [WORD_W-1:0] reg_count,
                            input logic [WORD_W-1:0] vector_base);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= CFG_REG_COUNT;
    cfg_ch.wr_data   <= reg_count;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.reg_index <= CFG_VECTOR_BASE;
    cfg_ch.wr_data   <= vector_base;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Instruction request; the interrupt fields carry random noise.
  function automatic cpu_req_t mk_instr(input logic [OP_W-1:0] op,
                                        input logic [RIDX_W-1:0] rd,
                                        input logic [RIDX_W-1:0] rs,
                                        input logic [IMM_W-1:0] imm,
                                        input logic [WORD_W-1:0] lword);
    cpu_req_t r;
    r.req_type = REQ_EXEC;
    r.irq_number = IRQ_W'($urandom_range(31));
    r.vector_word = $urandom;
    r.op_code = op;
    r.dest_reg = rd;
    r.src_reg = rs;
    r.imm_value = imm;
    r.load_word = lword;
    return r;
  endfunction

  // Interrupt entry request; the instruction fields carry random noise.
  function automatic cpu_req_t mk_irq(input logic [IRQ_W-1:0] num,
                                      input logic [WORD_W-1:0] vword);
    cpu_req_t r;
    r = mk_instr(OP_W'($urandom_range(15)), RIDX_W'($urandom_range(15)),
                 RIDX_W'($urandom_range(15)), IMM_W'($urandom), $urandom);
    r.req_type = REQ_IRQ;
    r.irq_number = num;
    r.vector_word = vword;
    return r;
  endfunction

  // Random request, mostly a well-formed program: registers mostly in range,
  // small immediates so compares hit, no halt inside a handler (that would
  // lock the core up), and interrupts to wake a halted core.
  function automatic cpu_req_t rand_req();
    cpu_req_t r;
    int unsigned n;
    int unsigned pick;
    n = regs_enabled();
    r = mk_instr(OP_W'($urandom_range(32'(OP_CMPI))),
                 RIDX_W'(($urandom_range(99) < 85) ? $urandom_range(n - 1)
                                                   : $urandom_range(15)),
                 RIDX_W'(($urandom_range(99) < 85) ? $urandom_range(n - 1)
                                                   : $urandom_range(15)),
                 IMM_W'(($urandom_range(1) != 0) ? $urandom_range(3) : $urandom),
                 ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom);
    if ($urandom_range(3) == 0) r.vector_word = $urandom_range(255);
    pick = $urandom_range(99);
    if (pick < 5 || (gen_halted && pick < 50)) r.req_type = REQ_IRQ;
    else if (pick < 8) r.op_code = ($urandom_range(1) != 0) ? OP_UNUSED_A : OP_UNUSED_B;
    else if (pick < 11) r.op_code = gen_in_isr ? OP_NOP : OP_HALT;
    else if (pick < 17) r.op_code = OP_RETI;

    // Track where the halt and handler flags will be after this request.
    if (r.req_type == REQ_IRQ) begin
      if (!gen_in_isr) begin
        gen_in_isr = 1'b1;
        gen_halted = 1'b0;
      end
    end else if (!gen_halted) begin
      if (r.op_code == OP_HALT) gen_halted = 1'b1;
      else if (r.op_code == OP_RETI) gen_in_isr = 1'b0;
    end
    return r;
  endfunction

  // Every opcode, extreme values, wrapping, interrupts, halt and faults.
  task automatic test_directed_ops();
    drain();
    set_config(WORD_W'(RCNT_RESET), '0);
    send_req(mk_instr(OP_MOVI, 4'd0, 4'd9, 16'hFFFF, 32'd0));
    send_req(mk_instr(OP_MOVI, 4'd15, 4'd0, 16'h0000, 32'hFFFF_FFFF));
    send_req(mk_instr(OP_LOAD, 4'd1, 4'd3, 16'h1234, 32'hFFFF_FFFF));
    send_req(mk_instr(OP_STORE, 4'd1, 4'd15, 16'hFFFF, 32'd0));
    send_req(mk_instr(OP_MOV, 4'd2, 4'd1, 16'h0000, 32'd0));
    // Sums and differences that wrap at 32 bits.
    send_req(mk_instr(OP_ADD, 4'd2, 4'd1, 16'h0000, 32'd0));
    send_req(mk_instr(OP_SUB, 4'd15, 4'd1, 16'h0000, 32'd0));
    send_req(mk_instr(OP_CMP, 4'd2, 4'd2, 16'h0000, 32'd0));
    send_req(mk_instr(OP_JZ, 4'd0, 4'd0, 16'h0010, 32'd0));
    send_req(mk_instr(OP_CMPI, 4'd0, 4'd0, 16'hFFFF, 32'd0));
    send_req(mk_instr(OP_JNZ, 4'd0, 4'd0, 16'h0020, 32'd0));
    send_req(mk_instr(OP_CMPI, 4'd15, 4'd0, 16'h0000, 32'd0));
    send_req(mk_instr(OP_JNZ, 4'd15, 4'd15, 16'h0030, 32'd0));
    send_req(mk_instr(OP_JZ, 4'd15, 4'd15, 16'h0040, 32'd0));
    send_req(mk_instr(OP_JMP, 4'd7, 4'd8, 16'hFFFF, 32'd0));
    send_req(mk_instr(OP_NOP, 4'd15, 4'd15, 16'hFFFF, 32'hFFFF_FFFF));
    send_req(mk_instr(OP_UNUSED_A, 4'd0, 4'd0, 16'h0000, 32'd0));
    send_req(mk_instr(OP_UNUSED_B, 4'd15, 4'd15, 16'hFFFF, 32'd0));
    // Return with no handler running is a fault.
    send_req(mk_instr(OP_RETI, 4'd0, 4'd0, 16'h0000, 32'd0));
    send_req(mk_irq(5'd31, 32'hFFFF_FFFF));
    // A second interrupt while the handler runs is ignored.
    send_req(mk_irq(5'd0, 32'h0000_0000));
    // Program counter wraps from all ones to zero.
    send_req(mk_instr(OP_NOP, 4'd0, 4'd0, 16'h0000, 32'd0));
    send_req(mk_instr(OP_RETI, 4'd15, 4'd15, 16'hFFFF, 32'd0));
    send_req(mk_instr(OP_HALT, 4'd0, 4'd0, 16'h0000, 32'd0));
    // Instructions are ignored while halted; an interrupt wakes the core.
    send_req(mk_instr(OP_MOVI, 4'd3, 4'd0, 16'h5555, 32'd0));
    send_req(mk_irq(5'd10, 32'h0000_0100));
    send_req(mk_instr(OP_RETI, 4'd0, 4'd0, 16'h0000, 32'd0));
  endtask

  // Register indexes against the register count, and vector address wrap.
  task automatic test_register_limits();
    drain();
    set_config(32'd3, 32'hFFFF_FFF0);
    send_req(mk_instr(OP_MOVI, 4'd2, 4'd15, 16'h0007, 32'd0));
    send_req(mk_instr(OP_MOVI, 4'd3, 4'd0, 16'h0001, 32'd0));
    send_req(mk_instr(OP_LOAD, 4'd3, 4'd0, 16'h0002, 32'h1234_5678));
    send_req(mk_instr(OP_STORE, 4'd3, 4'd0, 16'h0003, 32'd0));
    send_req(mk_instr(OP_MOV, 4'd2, 4'd3, 16'h0000, 32'd0));
    send_req(mk_instr(OP_ADD, 4'd3, 4'd0, 16'h0000, 32'd0));
    send_req(mk_instr(OP_SUB, 4'd0, 4'd15, 16'h0000, 32'd0));
    send_req(mk_instr(OP_CMP, 4'd0, 4'd3, 16'h0000, 32'd0));
    send_req(mk_instr(OP_CMPI, 4'd3, 4'd0, 16'h0000, 32'd0));
    // Jumps, no-ops and returns check no register index.
    send_req(mk_instr(OP_JMP, 4'd15, 4'd15, 16'h0100, 32'd0));
    send_req(mk_instr(OP_NOP, 4'd15, 4'd15, 16'h0000, 32'd0));
    send_req(mk_irq(5'd31, 32'h0000_0200));
    send_req(mk_instr(OP_RETI, 4'd15, 4'd15, 16'h0000, 32'd0));

    // A register count of zero acts as one.
    drain();
    set_config(32'd0, 32'h0000_0000);
    send_req(mk_instr(OP_MOVI, 4'd0, 4'd0, 16'h00AA, 32'd0));
    send_req(mk_instr(OP_MOVI, 4'd1, 4'd0, 16'h00BB, 32'd0));
    send_req(mk_instr(OP_MOV, 4'd0, 4'd0, 16'h0000, 32'd0));
    send_req(mk_instr(OP_MOV, 4'd0, 4'd1, 16'h0000, 32'd0));

    // Counts above sixteen act as sixteen; only the low five bits are kept.
    drain();
    set_config(32'hFFFF_FFFF, 32'h8000_0000);
    send_req(mk_instr(OP_MOVI, 4'd15, 4'd0, 16'h00CC, 32'd0));
    drain();
    set_config(32'd17, 32'h0000_0000);
    send_req(mk_instr(OP_MOV, 4'd15, 4'd0, 16'h0000, 32'd0));
    drain();
    set_config(32'd1, 32'h0000_0000);
    send_req(mk_instr(OP_STORE, 4'd0, 4'd0, 16'h0040, 32'd0));
    send_req(mk_instr(OP_STORE, 4'd1, 4'd0, 16'h0040, 32'd0));
  endtask

  // Random program traffic under one configuration and one idling pattern.
  task automatic test_random_traffic(input logic [WORD_W-1:0] reg_count,
                                     input logic [WORD_W-1:0] vector_base,
                                     input int unsigned in_pct, input int unsigned out_pct,
                                     input int unsigned n_items);
    drain();
    set_config(reg_count, vector_base);
    gen_in_isr = st_in_isr;
    gen_halted = st_halted;
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    repeat (n_items) send_req(rand_req());
    in_idle_pct = 0;
    out_stall_pct = 0;
  endtask

  // The receiver holds off while requests keep coming, so the core fills and stalls its input.
  task automatic test_backpressure();
    drain();
    set_config(WORD_W'(RCNT_RESET), $urandom);
    gen_in_isr = st_in_isr;
    gen_halted = st_halted;
    stall_hold = 60;
    repeat (30) send_req(rand_req());
  endtask

  // Test sequence.
  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_EXEC;
    in_ch.irq_number  <= '0;
    in_ch.vector_word <= '0;
    in_ch.op_code     <= OP_NOP;
    in_ch.dest_reg    <= '0;
    in_ch.src_reg     <= '0;
    in_ch.imm_value   <= '0;
    in_ch.load_word   <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.reg_index  <= CFG_REG_COUNT;
    cfg_ch.wr_data    <= '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    stall_hold = 0;
    err_count = 0;
    result_num = 0;
    reset_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_register_limits();
    test_random_traffic(32'd16, 32'd0, 0, 0, 180);
    test_random_traffic(32'd5, $urandom, 86, 0, 180);
    test_random_traffic(32'd31, 32'hFFFF_FFFF, 0, 86, 180);
    test_random_traffic(32'd2, $urandom, 19, 19, 180);
    test_backpressure();
    drain();

    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tce_pkg.sv
hw/rtl/tce_in_if.sv
hw/rtl/tce_out_if.sv
hw/rtl/tce_cfg_if.sv
hw/rtl/tiny_cpu_execute_core.sv
bench/tiny_cpu_execute_core_tb.sv
